/* sv/flsb_pkg.sv */
`default_nettype none
package flsb_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int FAIL_W  = 8;
    localparam int SECS_W  = 16;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [FAIL_W-1:0] FAIL_MAX       = '1;
    localparam logic [FAIL_W-1:0] LIMIT_RESET    = 8'd5;
    localparam logic [SECS_W-1:0] BLOCK_RESET    = 16'd300;

    typedef enum logic [REQ_W-1:0] {
        REQ_CHECK   = 2'd0,
        REQ_FAIL    = 2'd1,
        REQ_SUCCESS = 2'd2,
        REQ_COUNT   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT = 1'd0,
        CFG_BLOCK = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [FAIL_W-1:0] cnt;
        logic              blk;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

/* sv/flsb_if.sv */
`default_nettype none
interface flsb_in_if;
    logic                            valid;
    logic                            ready;
    logic [flsb_pkg::REQ_W-1:0]      req_type;
    logic [flsb_pkg::ADDR_W-1:0]     source_addr;
    logic [flsb_pkg::TIME_W-1:0]     now_seconds;

    modport source (output valid, req_type, source_addr, now_seconds, input ready);
    modport sink   (input valid, req_type, source_addr, now_seconds, output ready);
endinterface

interface flsb_out_if;
    logic                            valid;
    logic                            ready;
    logic                            blk_flag;
    logic [flsb_pkg::FAIL_W-1:0]     fail_count;
    logic                            table_full;

    modport source (output valid, blk_flag, fail_count, table_full, input ready);
    modport sink   (input valid, blk_flag, fail_count, table_full, output ready);
endinterface

interface flsb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [flsb_pkg::CFG_IDX_W-1:0]    index;
    logic [flsb_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/flsb_ram.sv */
`default_nettype none
module flsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* sv/flsb_apply.sv */
`default_nettype none
module flsb_apply (
    input  wire flsb_pkg::t_entry                  i_ent,
    input  wire flsb_pkg::t_req                    i_req,
    input  wire logic [flsb_pkg::TIME_W-1:0]       i_now,
    input  wire logic [flsb_pkg::FAIL_W-1:0]       i_limit,
    input  wire logic [flsb_pkg::SECS_W-1:0]       i_block_secs,
    output flsb_pkg::t_entry                       o_ent
);

    logic [flsb_pkg::TIME_W:0]   sum;
    logic [flsb_pkg::TIME_W-1:0] until_sat;
    logic [flsb_pkg::FAIL_W-1:0] cnt_inc;

    assign sum = {1'b0, i_now} + {{(flsb_pkg::TIME_W + 1 - flsb_pkg::SECS_W){1'b0}}, i_block_secs};
    assign until_sat = sum[flsb_pkg::TIME_W] ? '1 : sum[flsb_pkg::TIME_W-1:0];
    assign cnt_inc = (i_ent.cnt != flsb_pkg::FAIL_MAX) ? i_ent.cnt + 1'b1 : i_ent.cnt;

    always_comb begin
        o_ent = i_ent;
        case (i_req)
            flsb_pkg::REQ_FAIL: begin
                o_ent.cnt = cnt_inc;
                if (cnt_inc >= i_limit) begin
                    o_ent.blk    = 1'b1;
                    o_ent.expiry = until_sat;
                end
            end
            flsb_pkg::REQ_SUCCESS: begin
                o_ent.cnt = '0;
                o_ent.blk = 1'b0;
            end
            flsb_pkg::REQ_CHECK, flsb_pkg::REQ_COUNT: begin
                o_ent = i_ent;
            end
            default: begin
                o_ent = i_ent;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/failed_login_source_blocker_unit.sv */
// Failed-login source blocker.
// i_req carries one request item: req_type, source_addr, now_seconds. o_res
// returns one result item per request: blk_flag, fail_count, table_full.
// i_cfg writes attempt_limit (index 0) or block_seconds (index 1); it is
// always ready and should only be used while no request is in flight.
// A request is looked up by scanning the entry RAM one entry per cycle
// through a single key comparator. A found entry is checked for expiry; a
// found or new entry is then updated and written back. When the table is
// full, no entry is written and the result is returned with table_full set.
// Only one request is in work at a time; i_req.ready is high only when idle,
// so the next item can be accepted in the same cycle the result shows up.
// The result sits in an output register, so the next request is accepted
// while a result waits. If o_res stalls and a second result is done, the
// block holds it internally until the output register frees up.
// Reset empties the table (entries_used = 0) and restores attempt_limit 5
// and block_seconds 300; no clearing pass is needed.
`default_nettype none
module failed_login_source_blocker_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    flsb_in_if.sink    i_req,
    flsb_out_if.source o_res,
    flsb_cfg_if.sink   i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EXP   = 5'b00100,
        S_APPLY = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic [flsb_pkg::CNT_W-1:0]     r_idx, n_idx;
    logic [flsb_pkg::CNT_W-1:0]     r_used, n_used;
    logic                           r_pend, n_pend;
    logic [flsb_pkg::IDX_W-1:0]     r_pidx, n_pidx;
    logic [flsb_pkg::IDX_W-1:0]     r_slot, n_slot;
    flsb_pkg::t_entry               r_ent, n_ent;
    flsb_pkg::t_req                 r_req, n_req;
    logic [flsb_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [flsb_pkg::TIME_W-1:0]    r_now, n_now;
    logic                           r_full, n_full;
    logic [flsb_pkg::FAIL_W-1:0]    r_limit;
    logic [flsb_pkg::SECS_W-1:0]    r_bsecs;
    logic                           r_ovalid, n_ovalid;
    logic                           r_oblk, n_oblk;
    logic [flsb_pkg::FAIL_W-1:0]    r_ocnt, n_ocnt;
    logic                           r_ofull, n_ofull;

    logic [flsb_pkg::ENTRY_W-1:0]   ram_rdata;
    flsb_pkg::t_entry               rd_ent;
    flsb_pkg::t_entry               upd_ent;
    logic                           ram_we;
    logic                           hit;

    assign rd_ent = flsb_pkg::t_entry'(ram_rdata);
    assign hit    = r_pend && (rd_ent.key == r_addr);
    assign ram_we = (r_state == S_APPLY);

    flsb_ram #(
        .WIDTH (flsb_pkg::ENTRY_W),
        .DEPTH (flsb_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (upd_ent),
        .i_raddr (r_idx[flsb_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    flsb_apply u_apply (
        .i_ent        (r_ent),
        .i_req        (r_req),
        .i_now        (r_now),
        .i_limit      (r_limit),
        .i_block_secs (r_bsecs),
        .o_ent        (upd_ent)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_ovalid;
    assign o_res.blk_flag   = r_oblk;
    assign o_res.fail_count = r_ocnt;
    assign o_res.table_full = r_ofull;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_used   = r_used;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_slot   = r_slot;
        n_ent    = r_ent;
        n_req    = r_req;
        n_addr   = r_addr;
        n_now    = r_now;
        n_full   = r_full;
        n_ovalid = r_ovalid && !o_res.ready;
        n_oblk   = r_oblk;
        n_ocnt   = r_ocnt;
        n_ofull  = r_ofull;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = flsb_pkg::t_req'(i_req.req_type);
                    n_addr  = i_req.source_addr;
                    n_now   = i_req.now_seconds;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_full  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_ent   = rd_ent;
                    n_slot  = r_pidx;
                    n_pend  = 1'b0;
                    n_state = S_EXP;
                end else if (r_idx == r_used) begin
                    n_pend = 1'b0;
                    if (r_used == flsb_pkg::CNT_W'(flsb_pkg::TABLE_DEPTH)) begin
                        n_full    = 1'b1;
                        n_ent.cnt = '0;
                        n_ent.blk = 1'b0;
                        n_state   = S_OUT;
                    end else begin
                        n_ent.key    = r_addr;
                        n_ent.cnt    = '0;
                        n_ent.blk    = 1'b0;
                        n_ent.expiry = '0;
                        n_slot       = r_used[flsb_pkg::IDX_W-1:0];
                        n_used       = r_used + 1'b1;
                        n_state      = S_APPLY;
                    end
                end else begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[flsb_pkg::IDX_W-1:0];
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_EXP: begin
                if (r_ent.blk && (r_now >= r_ent.expiry)) begin
                    n_ent.blk = 1'b0;
                    n_ent.cnt = '0;
                end
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_ent   = upd_ent;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_oblk   = r_ent.blk & ~r_full;
                    n_ocnt   = r_ent.cnt;
                    n_ofull  = r_full;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_limit  <= flsb_pkg::LIMIT_RESET;
            r_bsecs  <= flsb_pkg::BLOCK_RESET;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid) begin
                case (flsb_pkg::t_cfg_idx'(i_cfg.index))
                    flsb_pkg::CFG_LIMIT: r_limit <= i_cfg.data[flsb_pkg::FAIL_W-1:0];
                    flsb_pkg::CFG_BLOCK: r_bsecs <= i_cfg.data[flsb_pkg::SECS_W-1:0];
                    default: begin
                        r_limit <= r_limit;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_slot  <= n_slot;
        r_ent   <= n_ent;
        r_req   <= n_req;
        r_addr  <= n_addr;
        r_now   <= n_now;
        r_full  <= n_full;
        r_oblk  <= n_oblk;
        r_ocnt  <= n_ocnt;
        r_ofull <= n_ofull;
    end

endmodule
`default_nettype wire

/* sv/flsb_chk.sv */
`default_nettype none
module flsb_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_blk_flag,
    input wire logic [flsb_pkg::FAIL_W-1:0]   i_fail_count,
    input wire logic                          i_table_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_blk_flag)
            && $stable(i_fail_count) && $stable(i_table_full))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after an accepted item");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> !i_blk_flag && (i_fail_count == '0))
        else $error("table full result carries entry data");

    a_blocked_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_blk_flag |-> (i_fail_count != '0))
        else $error("blocked source with zero failure count");

endmodule

bind failed_login_source_blocker_unit flsb_chk u_flsb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_blk_flag   (o_res.blk_flag),
    .i_fail_count (o_res.fail_count),
    .i_table_full (o_res.table_full)
);
`default_nettype wire
